// ===== design/lcpe_pkg.sv =====
package lcpe_pkg;

    localparam int NUM_TYPES  = 4;
    localparam int TYPE_W     = 2;
    localparam int CHG_W      = 16;
    localparam int FX_W       = 32;
    localparam int E_W        = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // pipeline unit lengths, one quotient or root bit per stage
    localparam int LJD_N = 37;
    localparam int SQ_N  = 32;
    localparam int CD_N  = 63;

    localparam logic [31:0] LJ_CUT_RST   = 32'd167772160;
    localparam logic [31:0] COUL_CUT_RST = 32'd167772160;
    localparam logic [31:0] DIEL_RST     = 32'd16777216;

    // 14.36 in Q.24
    localparam logic [27:0] COUL_K   = 28'd240920822;
    localparam logic [61:0] TERM_CAP = {1'b1, 61'b0};

    localparam logic signed [63:0] E_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] E_MIN = -64'sd140737488355328;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LJ_CUT   = 3'd0,
        CFG_COUL_CUT = 3'd1,
        CFG_DIEL     = 3'd2,
        CFG_TYPE0    = 3'd3,
        CFG_TYPE1    = 3'd4,
        CFG_TYPE2    = 3'd5,
        CFG_TYPE3    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic coinc;
        logic lj_en;
        logic c_en;
        logic big;   // sigma/r at or above 16
        logic neg;   // q1*q2 negative
        logic ovf;   // Coulomb quotient at or above 2^63
    } t_ctl;

endpackage

// ===== design/lj_coulomb_pair_energy_top.sv =====
// Throughput: one pair per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the 63-stage Coulomb divider (one quotient bit per stage).
// Reset (synchronous, active low) clears valid bits and loads register defaults.
// Results appear for one cycle on o_done; the receiver cannot stall.
module lj_coulomb_pair_energy_top
    import lcpe_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [TYPE_W-1:0]            i_first_type,
    input  logic [TYPE_W-1:0]            i_second_type,
    input  logic signed [CHG_W-1:0]      i_first_charge,
    input  logic signed [CHG_W-1:0]      i_second_charge,
    input  logic [FX_W-1:0]              i_separation,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                         o_done,
    output logic signed [E_W-1:0]        o_pair_energy,
    output logic                         o_coincident,
    output logic                         o_saturated
);

    // configuration registers
    logic [31:0] r_lj_cut, r_coul_cut, r_diel;
    logic [63:0] r_tp0, r_tp1, r_tp2, r_tp3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lj_cut   <= LJ_CUT_RST;
            r_coul_cut <= COUL_CUT_RST;
            r_diel     <= DIEL_RST;
            r_tp0      <= '0;
            r_tp1      <= '0;
            r_tp2      <= '0;
            r_tp3      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LJ_CUT:   r_lj_cut   <= i_cfg_data[31:0];
                CFG_COUL_CUT: r_coul_cut <= i_cfg_data[31:0];
                CFG_DIEL:     r_diel     <= i_cfg_data[31:0];
                CFG_TYPE0:    r_tp0      <= i_cfg_data;
                CFG_TYPE1:    r_tp1      <= i_cfg_data;
                CFG_TYPE2:    r_tp2      <= i_cfg_data;
                CFG_TYPE3:    r_tp3      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic [63:0] w_tpa, w_tpb;

    always_comb begin
        unique case (i_first_type)
            2'd0:    w_tpa = r_tp0;
            2'd1:    w_tpa = r_tp1;
            2'd2:    w_tpa = r_tp2;
            default: w_tpa = r_tp3;
        endcase
        if (int'(i_first_type) >= NUM_TYPES) w_tpa = '0;
        unique case (i_second_type)
            2'd0:    w_tpb = r_tp0;
            2'd1:    w_tpb = r_tp1;
            2'd2:    w_tpb = r_tp2;
            default: w_tpb = r_tp3;
        endcase
        if (int'(i_second_type) >= NUM_TYPES) w_tpb = '0;
    end

    // control travels with the data
    t_ctl r_ctl [1:70];
    t_ctl n_ctl1;

    logic [32:0] r1_sigsum;
    logic [31:0] r1_ea, r1_eb, r1_r;
    logic signed [15:0] r1_q1, r1_q2;

    always_comb begin
        n_ctl1       = '0;
        n_ctl1.valid = start && !busy;
        n_ctl1.coinc = (i_separation == '0);
        n_ctl1.lj_en = (i_separation < r_lj_cut);
        n_ctl1.c_en  = (i_separation < r_coul_cut);
    end

    // stage 1: type lookup
    always_ff @(posedge i_clk) begin
        r1_sigsum <= 33'(w_tpa[63:32]) + 33'(w_tpb[63:32]);
        r1_ea     <= w_tpa[31:0];
        r1_eb     <= w_tpb[31:0];
        r1_q1     <= i_first_charge;
        r1_q2     <= i_second_charge;
        r1_r      <= i_separation;
    end

    logic w_big, w_neg, w_ovf;
    t_ctl n_ctl2, n_ctl3, n_ctl5;

    always_comb begin
        n_ctl2     = r_ctl[1];
        n_ctl2.big = w_big;
        n_ctl3     = r_ctl[2];
        n_ctl3.neg = w_neg;
        n_ctl5     = r_ctl[4];
        n_ctl5.ovf = w_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 70; k++) r_ctl[k] <= '0;
        end else begin
            r_ctl[1] <= n_ctl1;
            r_ctl[2] <= n_ctl2;
            r_ctl[3] <= n_ctl3;
            r_ctl[4] <= r_ctl[3];
            r_ctl[5] <= n_ctl5;
            for (int k = 6; k <= 70; k++) r_ctl[k] <= r_ctl[k-1];
        end
    end

    assign w_big = ({6'b0, r1_sigsum} >= {2'b0, r1_r, 5'b0});

    // ---------------- LJ: sigma/r divider, stages 2..39 ----------------
    logic [31:0] r_ljd_rem [0:LJD_N-1];
    logic [36:0] r_ljd_nb  [0:LJD_N-1];
    logic [31:0] r_ljd_d   [0:LJD_N-1];
    logic [36:0] r_ljd_q   [0:LJD_N];

    always_ff @(posedge i_clk) begin
        r_ljd_rem[0] <= 32'(r1_sigsum[32:6]);
        r_ljd_nb[0]  <= {r1_sigsum[5:0], 31'b0};
        r_ljd_d[0]   <= r1_r;
        r_ljd_q[0]   <= '0;
    end

    for (genvar j = 1; j <= LJD_N; j++) begin : g_ljd
        logic [32:0] w_t;
        logic        w_ge;
        assign w_t  = {r_ljd_rem[j-1], r_ljd_nb[j-1][36]};
        assign w_ge = (w_t >= {1'b0, r_ljd_d[j-1]});
        always_ff @(posedge i_clk) begin
            r_ljd_q[j] <= {r_ljd_q[j-1][35:0], w_ge};
        end
        if (j < LJD_N) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_ljd_rem[j] <= w_ge ? 32'(w_t - {1'b0, r_ljd_d[j-1]}) : w_t[31:0];
                r_ljd_nb[j]  <= {r_ljd_nb[j-1][35:0], 1'b0};
                r_ljd_d[j]   <= r_ljd_d[j-1];
            end
        end
    end

    // ---------------- LJ: sqrt(eps_a*eps_b), stages 2..34 ----------------
    logic [33:0] r_sq_rem  [0:SQ_N-1];
    logic [63:0] r_sq_x    [0:SQ_N-1];
    logic [31:0] r_sq_root [0:SQ_N];

    always_ff @(posedge i_clk) begin
        r_sq_rem[0]  <= '0;
        r_sq_x[0]    <= r1_ea * r1_eb;
        r_sq_root[0] <= '0;
    end

    for (genvar j = 1; j <= SQ_N; j++) begin : g_sq
        logic [35:0] w_t;
        logic [35:0] w_trial;
        logic        w_ge;
        assign w_t     = {r_sq_rem[j-1], r_sq_x[j-1][63:62]};
        assign w_trial = {2'b0, r_sq_root[j-1], 2'b01};
        assign w_ge    = (w_t >= w_trial);
        always_ff @(posedge i_clk) begin
            r_sq_root[j] <= {r_sq_root[j-1][30:0], w_ge};
        end
        if (j < SQ_N) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_sq_rem[j] <= w_ge ? 34'(w_t - w_trial) : w_t[33:0];
                r_sq_x[j]   <= {r_sq_x[j-1][61:0], 2'b0};
            end
        end
    end

    logic [31:0] r_ep [35:48];

    always_ff @(posedge i_clk) begin
        r_ep[35] <= r_sq_root[SQ_N];
        for (int k = 36; k <= 48; k++) r_ep[k] <= r_ep[k-1];
    end

    // ---------------- LJ: powers of x, x^12 - x^6 and eps product, stages 40..50 ----------------
    logic [35:0] w_x;
    assign w_x = r_ljd_q[LJD_N][35:0];

    logic [63:0] r40_ll;
    logic [35:0] r40_lh;
    logic [7:0]  r40_hh;
    logic [35:0] r40_x, r41_x;
    logic [39:0] r41_x2;
    logic [71:0] w_s41;

    always_ff @(posedge i_clk) begin
        r40_ll <= w_x[31:0] * w_x[31:0];
        r40_lh <= w_x[31:0] * w_x[35:32];
        r40_hh <= w_x[35:32] * w_x[35:32];
        r40_x  <= w_x;
    end

    assign w_s41 = {r40_hh, 64'b0} + 72'({r40_lh, 33'b0}) + 72'(r40_ll);

    always_ff @(posedge i_clk) begin
        r41_x2 <= w_s41[71:32];
        r41_x  <= r40_x;
    end

    logic [63:0] r42_ll;
    logic [35:0] r42_lh;
    logic [39:0] r42_hl;
    logic [11:0] r42_hh;
    logic [43:0] r43_x3;
    logic [75:0] w_s43;

    always_ff @(posedge i_clk) begin
        r42_ll <= r41_x2[31:0] * r41_x[31:0];
        r42_lh <= r41_x2[31:0] * r41_x[35:32];
        r42_hl <= r41_x2[39:32] * r41_x[31:0];
        r42_hh <= r41_x2[39:32] * r41_x[35:32];
    end

    assign w_s43 = {r42_hh, 64'b0} + 76'({r42_lh, 32'b0}) + 76'({r42_hl, 32'b0})
                 + 76'(r42_ll);

    always_ff @(posedge i_clk) begin
        r43_x3 <= w_s43[75:32];
    end

    logic [63:0] r44_ll;
    logic [43:0] r44_lh;
    logic [23:0] r44_hh;
    logic [55:0] r45_x6;
    logic [87:0] w_s45;

    always_ff @(posedge i_clk) begin
        r44_ll <= r43_x3[31:0] * r43_x3[31:0];
        r44_lh <= r43_x3[31:0] * r43_x3[43:32];
        r44_hh <= r43_x3[43:32] * r43_x3[43:32];
    end

    assign w_s45 = {r44_hh, 64'b0} + 88'({r44_lh, 33'b0}) + 88'(r44_ll);

    always_ff @(posedge i_clk) begin
        r45_x6 <= w_s45[87:32];
    end

    logic [63:0]  r46_ll;
    logic [55:0]  r46_lh;
    logic [47:0]  r46_hh;
    logic [55:0]  r46_x6, r47_x6;
    logic [111:0] r47_p;

    always_ff @(posedge i_clk) begin
        r46_ll <= r45_x6[31:0] * r45_x6[31:0];
        r46_lh <= r45_x6[31:0] * r45_x6[55:32];
        r46_hh <= r45_x6[55:32] * r45_x6[55:32];
        r46_x6 <= r45_x6;
        r47_p  <= {r46_hh, 64'b0} + 112'({r46_lh, 33'b0}) + 112'(r46_ll);
        r47_x6 <= r46_x6;
    end

    // x^12 - x^6, magnitude and sign
    logic [111:0] w_q48, w_pq, w_qp;
    logic         w_pos48;
    logic [63:0]  r48_d16;
    logic         r48_pos;

    assign w_q48   = 112'({r47_x6, 32'b0});
    assign w_pos48 = (r47_p >= w_q48);
    assign w_pq    = r47_p - w_q48;
    assign w_qp    = w_q48 - r47_p;

    always_ff @(posedge i_clk) begin
        r48_d16 <= w_pos48 ? w_pq[111:48] : w_qp[111:48];
        r48_pos <= w_pos48;
    end

    logic [63:0] r49_pl, r49_ph;
    logic        r49_pos, r49_epnz;

    always_ff @(posedge i_clk) begin
        r49_pl   <= r_ep[48] * r48_d16[31:0];
        r49_ph   <= r_ep[48] * r48_d16[63:32];
        r49_pos  <= r48_pos;
        r49_epnz <= (r_ep[48] != '0);
    end

    logic [95:0]        w_prod50;
    logic [81:0]        w_mag50;
    logic [61:0]        w_cap50;
    logic signed [62:0] n_ljt;
    logic signed [62:0] r_ljt [50:69];

    assign w_prod50 = {r49_ph, 32'b0} + 96'(r49_pl);
    assign w_mag50  = w_prod50[95:14];
    assign w_cap50  = (w_mag50 > 82'(TERM_CAP)) ? TERM_CAP : w_mag50[61:0];

    always_comb begin
        if (!r_ctl[49].lj_en) begin
            n_ljt = '0;
        end else if (r_ctl[49].big) begin
            n_ljt = r49_epnz ? $signed({1'b0, TERM_CAP}) : '0;
        end else begin
            n_ljt = r49_pos ? $signed({1'b0, w_cap50}) : -$signed({1'b0, w_cap50});
        end
    end

    always_ff @(posedge i_clk) begin
        r_ljt[50] <= n_ljt;
        for (int k = 51; k <= 69; k++) r_ljt[k] <= r_ljt[k-1];
    end

    // ---------------- Coulomb, stages 2..69 ----------------
    logic signed [31:0] r2_qq;
    logic [63:0]        r2_den, r3_den, r4_den;
    logic [31:0]        w_diel;
    logic [31:0]        w_qabs;
    logic [30:0]        r3_qmag;
    logic [58:0]        w_mk;
    logic [57:0]        r4_mk;

    assign w_diel = (r_diel == '0) ? 32'd1 : r_diel;

    always_ff @(posedge i_clk) begin
        r2_qq  <= r1_q1 * r1_q2;
        r2_den <= r1_r * w_diel;
    end

    assign w_neg  = r2_qq[31];
    assign w_qabs = r2_qq[31] ? 32'(-r2_qq) : 32'(r2_qq);

    always_ff @(posedge i_clk) begin
        r3_qmag <= w_qabs[30:0];
        r3_den  <= r2_den;
    end

    assign w_mk = r3_qmag * COUL_K;

    always_ff @(posedge i_clk) begin
        r4_mk  <= w_mk[57:0];
        r4_den <= r3_den;
    end

    // numerator is mk * 2^24; top part seeds the remainder
    assign w_ovf = (64'(r4_mk[57:39]) >= r4_den);

    logic [63:0] r_cd_rem [0:CD_N-1];
    logic [62:0] r_cd_nb  [0:CD_N-1];
    logic [63:0] r_cd_d   [0:CD_N-1];
    logic [62:0] r_cd_q   [0:CD_N];

    always_ff @(posedge i_clk) begin
        r_cd_rem[0] <= 64'(r4_mk[57:39]);
        r_cd_nb[0]  <= {r4_mk[38:0], 24'b0};
        r_cd_d[0]   <= r4_den;
        r_cd_q[0]   <= '0;
    end

    for (genvar j = 1; j <= CD_N; j++) begin : g_cd
        logic [64:0] w_t;
        logic        w_ge;
        assign w_t  = {r_cd_rem[j-1], r_cd_nb[j-1][62]};
        assign w_ge = (w_t >= {1'b0, r_cd_d[j-1]});
        always_ff @(posedge i_clk) begin
            r_cd_q[j] <= {r_cd_q[j-1][61:0], w_ge};
        end
        if (j < CD_N) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_cd_rem[j] <= w_ge ? 64'(w_t - {1'b0, r_cd_d[j-1]}) : w_t[63:0];
                r_cd_nb[j]  <= {r_cd_nb[j-1][61:0], 1'b0};
                r_cd_d[j]   <= r_cd_d[j-1];
            end
        end
    end

    logic [61:0]        w_ccap;
    logic signed [62:0] r_ct69;

    assign w_ccap = (r_ctl[68].ovf || (r_cd_q[CD_N] > 63'(TERM_CAP))) ?
                    TERM_CAP : r_cd_q[CD_N][61:0];

    always_ff @(posedge i_clk) begin
        if (!r_ctl[68].c_en) begin
            r_ct69 <= '0;
        end else begin
            r_ct69 <= r_ctl[68].neg ? -$signed({1'b0, w_ccap}) : $signed({1'b0, w_ccap});
        end
    end

    // ---------------- sum and saturate, stage 70 ----------------
    logic signed [63:0] w_sum;
    logic signed [E_W-1:0] r_energy;
    logic                  r_coinc, r_sat;

    assign w_sum = 64'(r_ljt[69]) + 64'(r_ct69);

    always_ff @(posedge i_clk) begin
        if (r_ctl[69].coinc) begin
            r_energy <= '0;
            r_coinc  <= 1'b1;
            r_sat    <= 1'b0;
        end else if (w_sum > E_MAX) begin
            r_energy <= E_MAX[E_W-1:0];
            r_coinc  <= 1'b0;
            r_sat    <= 1'b1;
        end else if (w_sum < E_MIN) begin
            r_energy <= E_MIN[E_W-1:0];
            r_coinc  <= 1'b0;
            r_sat    <= 1'b1;
        end else begin
            r_energy <= w_sum[E_W-1:0];
            r_coinc  <= 1'b0;
            r_sat    <= 1'b0;
        end
    end

    assign o_done        = r_ctl[70].valid;
    assign o_pair_energy = r_energy;
    assign o_coincident  = r_coinc;
    assign o_saturated   = r_sat;

    // ---------------- assertions ----------------
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_ctl[1].valid)
        else $error("accepted transaction did not enter the pipeline");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[1].valid |-> ##69 o_done)
        else $error("transaction lost in the pipeline");

    a_coinc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_coincident |-> (o_pair_energy == '0) && !o_saturated)
        else $error("coincident result carries energy");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_saturated |->
            (o_pair_energy == E_MAX[E_W-1:0]) || (o_pair_energy == E_MIN[E_W-1:0]))
        else $error("saturated result not at a bound");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[39].valid && !r_ctl[39].big |-> !r_ljd_q[LJD_N][36])
        else $error("sigma/r quotient out of range");

endmodule

// ===== tb/sv/lj_coulomb_pair_energy_checker.sv =====
`timescale 1ns / 100ps

module lj_coulomb_pair_energy_checker
    import lcpe_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_busy,
    input  logic [TYPE_W-1:0]       i_first_type,
    input  logic [TYPE_W-1:0]       i_second_type,
    input  logic [CHG_W-1:0]        i_first_charge,
    input  logic [CHG_W-1:0]        i_second_charge,
    input  logic [FX_W-1:0]         i_separation,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_done,
    input  logic [E_W-1:0]          i_pair_energy,
    input  logic                    i_coincident,
    input  logic                    i_saturated,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_sat_seen,
    output int                      o_coinc_seen
);

    typedef struct {
        logic [E_W-1:0] energy;
        logic           coinc;
        logic           sat;
    } t_energy_result;

    localparam logic [63:0] CAP64 = 64'd1 << 61;

    logic [31:0] lj_cut_r, coul_cut_r, diel_r;
    logic [63:0] type_tab [NUM_TYPES];
    t_energy_result energy_q[$];

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] lj_energy(logic [31:0] r, logic [63:0] ta,
                                                     logic [63:0] tb);
        logic [63:0]  sigsum, ep, x, x2, x3, x6, d16, mag;
        logic [127:0] p, q, diff, prod;
        logic         pos;
        sigsum = {32'd0, ta[63:32]} + {32'd0, tb[63:32]};
        ep = int_sqrt({32'd0, ta[31:0]} * {32'd0, tb[31:0]});
        if (ep == 0 || sigsum == 0) return 0;
        x = (sigsum << 31) / {32'd0, r};
        if (x >= (64'd1 << 36)) return $signed(CAP64);
        // x below 2^36, so the shifted results x2, x3 and x6 all fit in 64 bits
        x2 = 64'((128'(x) * 128'(x)) >> 32);
        x3 = 64'((128'(x2) * 128'(x)) >> 32);
        x6 = 64'((128'(x3) * 128'(x3)) >> 32);
        p = 128'(x6) * 128'(x6);
        q = 128'(x6) << 32;
        pos = (p >= q);
        diff = pos ? p - q : q - p;
        d16 = 64'(diff >> 48);
        prod = (128'(ep) * 128'(d16)) >> 14;
        mag = (prod > 128'(CAP64)) ? CAP64 : 64'(prod);
        return pos ? $signed(mag) : -$signed(mag);
    endfunction

    function automatic logic signed [63:0] coul_energy(logic [31:0] r, logic [15:0] c1,
                                                       logic [15:0] c2);
        longint      prod;
        logic [63:0] mag, den, cm;
        logic [127:0] num, quo;
        prod = longint'($signed(c1)) * longint'($signed(c2));
        mag = (prod < 0) ? 64'(-prod) : 64'(prod);
        den = {32'd0, r} * {32'd0, (diel_r == 0) ? 32'd1 : diel_r};
        num = (128'(mag) * 128'(COUL_K)) << 24;
        quo = num / 128'(den);
        cm = (quo > 128'(CAP64)) ? CAP64 : 64'(quo);
        return (prod < 0) ? -$signed(cm) : $signed(cm);
    endfunction

    function automatic t_energy_result pair_energy(logic [1:0] a, logic [1:0] b,
                                                   logic [15:0] c1, logic [15:0] c2,
                                                   logic [31:0] r);
        t_energy_result   res;
        logic signed [63:0] e;
        res.coinc = 0;
        res.sat = 0;
        res.energy = 0;
        if (r == 0) begin
            res.coinc = 1;
            return res;
        end
        e = 0;
        if (r < lj_cut_r) e = e + lj_energy(r, type_tab[a], type_tab[b]);
        if (r < coul_cut_r) e = e + coul_energy(r, c1, c2);
        if (e > E_MAX) begin
            e = E_MAX;
            res.sat = 1;
        end else if (e < E_MIN) begin
            e = E_MIN;
            res.sat = 1;
        end
        res.energy = e[E_W-1:0];
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
        o_sat_seen = 0;
        o_coinc_seen = 0;
    end

    always @(posedge i_clk) begin
        t_energy_result exp_r;
        if (!i_rst_n) begin
            lj_cut_r   <= LJ_CUT_RST;
            coul_cut_r <= COUL_CUT_RST;
            diel_r     <= DIEL_RST;
            for (int i = 0; i < NUM_TYPES; i++) type_tab[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LJ_CUT:   lj_cut_r   <= i_cfg_data[31:0];
                    CFG_COUL_CUT: coul_cut_r <= i_cfg_data[31:0];
                    CFG_DIEL:     diel_r     <= i_cfg_data[31:0];
                    CFG_TYPE0:    type_tab[0] <= i_cfg_data;
                    CFG_TYPE1:    type_tab[1] <= i_cfg_data;
                    CFG_TYPE2:    type_tab[2] <= i_cfg_data;
                    CFG_TYPE3:    type_tab[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                energy_q.push_back(pair_energy(i_first_type, i_second_type,
                                               i_first_charge, i_second_charge,
                                               i_separation));
            if (i_done) begin
                if (energy_q.size() == 0) begin
                    $display("%0t: result with no transaction pending: energy %h",
                             $time, i_pair_energy);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = energy_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (i_saturated) o_sat_seen <= o_sat_seen + 1;
                    if (i_coincident) o_coinc_seen <= o_coinc_seen + 1;
                    if (exp_r.energy !== i_pair_energy || exp_r.coinc !== i_coincident ||
                        exp_r.sat !== i_saturated) begin
                        $display("%0t: mismatch expected e=%h c=%b s=%b actual e=%h c=%b s=%b",
                                 $time, exp_r.energy, exp_r.coinc, exp_r.sat,
                                 i_pair_energy, i_coincident, i_saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= energy_q.size();
        end
    end

endmodule

// ===== tb/sv/lj_coulomb_pair_energy_top_tb.sv =====
`timescale 1ns / 100ps

module lj_coulomb_pair_energy_top_tb;
    import lcpe_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [TYPE_W-1:0]      i_first_type;
    logic [TYPE_W-1:0]      i_second_type;
    logic [CHG_W-1:0]       i_first_charge;
    logic [CHG_W-1:0]       i_second_charge;
    logic [FX_W-1:0]        i_separation;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   o_done;
    logic [E_W-1:0]         o_pair_energy;
    logic                   o_coincident;
    logic                   o_saturated;

    int fail_count, pending, checked, sat_seen, coinc_seen;
    int idle_pct;

    lj_coulomb_pair_energy_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_first_type(i_first_type), .i_second_type(i_second_type),
        .i_first_charge(i_first_charge), .i_second_charge(i_second_charge),
        .i_separation(i_separation), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_done(o_done), .o_pair_energy(o_pair_energy),
        .o_coincident(o_coincident), .o_saturated(o_saturated)
    );

    lj_coulomb_pair_energy_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_first_type(i_first_type), .i_second_type(i_second_type),
        .i_first_charge(i_first_charge), .i_second_charge(i_second_charge),
        .i_separation(i_separation), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_done(o_done), .i_pair_energy(o_pair_energy),
        .i_coincident(o_coincident), .i_saturated(o_saturated),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked),
        .o_sat_seen(sat_seen), .o_coinc_seen(coinc_seen)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Timeout");
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_pair(logic [1:0] a, logic [1:0] b, logic [15:0] c1,
                             logic [15:0] c2, logic [31:0] r);
        bit acc;
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_first_type <= a;
        i_second_type <= b;
        i_first_charge <= c1;
        i_second_charge <= c2;
        i_separation <= r;
        do begin
            @(negedge i_clk);
            acc = !busy;
            @(posedge i_clk);
        end while (!acc);
    endtask

    // drain the pipeline so registers are written with nothing in flight
    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (75) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [63:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_type_params();
        logic [31:0] sig, eps;
        sig = $urandom_range(32'h0400_0000, 32'h0080_0000);
        eps = (($urandom_range(9)) == 0) ? 32'd0 : $urandom_range(32'h0200_0000, 1);
        return {sig, eps};
    endfunction

    function automatic logic [31:0] rand_separation();
        case ($urandom_range(4))
            0: return $urandom();
            1: return $urandom_range(32'h0600_0000, 32'h0100_0000);
            2: return $urandom_range(32'h0200_0000, 32'h0040_0000);
            3: return $urandom_range(32'h0010_0000, 1);
            default: return $urandom_range(32'h0C00_0000, 32'h0400_0000);
        endcase
    endfunction

    task automatic random_pairs(int n);
        repeat (n)
            send_pair(2'($urandom()), 2'($urandom()), 16'($urandom()), 16'($urandom()),
                      rand_separation());
    endtask

    initial begin
        i_rst_n = 0;
        start = 0;
        i_first_type = 0;
        i_second_type = 0;
        i_first_charge = 0;
        i_second_charge = 0;
        i_separation = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_LJ_CUT;
        i_cfg_data = 0;
        idle_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset settings: LJ parameters all zero, Coulomb only
        send_pair(0, 0, 16'h1000, 16'h1000, 32'h0100_0000);
        send_pair(1, 2, 16'h7FFF, 16'h7FFF, 32'd1);
        send_pair(3, 3, 16'h8000, 16'h7FFF, 32'd1);
        send_pair(2, 1, 16'h8000, 16'h8000, 32'hFFFF_FFFF);
        send_pair(0, 3, 16'h0000, 16'h8000, 32'd0);
        drain();

        cfg_write(CFG_TYPE0, {32'h0100_0000, 32'h0100_0000});
        cfg_write(CFG_TYPE1, {32'h0200_0000, 32'h0080_0000});
        cfg_write(CFG_TYPE2, {32'h0000_0000, 32'h0100_0000});
        cfg_write(CFG_TYPE3, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
        cfg_write(CFG_DIEL, 64'h0000_0000_4E00_0000);
        // around the well minimum, at cutoff, large sigma/r, zero sigma sum
        send_pair(0, 0, 16'h1000, 16'hF000, 32'h011F_5D22);
        send_pair(0, 1, 16'h0800, 16'h0800, 32'h0180_0000);
        send_pair(1, 1, 16'h0000, 16'h0000, 32'h0A00_0000);
        send_pair(1, 1, 16'h0000, 16'h0000, 32'h09FF_FFFF);
        send_pair(0, 0, 16'h8000, 16'h7FFF, 32'h0008_0000);
        send_pair(2, 2, 16'h1000, 16'h1000, 32'h0080_0000);
        send_pair(3, 0, 16'h7FFF, 16'h8000, 32'h0100_0000);
        send_pair(3, 3, 16'h8000, 16'h8000, 32'hFFFF_FFFF);
        send_pair(0, 2, 16'h0001, 16'hFFFF, 32'd0);
        drain();

        // extremes: zero dielectric, cutoffs at both ends
        cfg_write(CFG_DIEL, 64'd0);
        cfg_write(CFG_LJ_CUT, 64'hFFFF_FFFF);
        cfg_write(CFG_COUL_CUT, 64'd0);
        send_pair(0, 0, 16'h7FFF, 16'h7FFF, 32'h0010_0000);
        send_pair(1, 3, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFE);
        drain();
        cfg_write(CFG_COUL_CUT, 64'hFFFF_FFFF);
        send_pair(0, 1, 16'h7FFF, 16'h8000, 32'd1);
        send_pair(2, 2, 16'h8000, 16'h8000, 32'd1);
        drain();

        cfg_write(CFG_DIEL, 64'd1);
        cfg_write(CFG_TYPE0, rand_type_params());
        cfg_write(CFG_TYPE1, rand_type_params());
        cfg_write(CFG_TYPE2, rand_type_params());
        cfg_write(CFG_TYPE3, rand_type_params());
        random_pairs(300);
        drain();

        cfg_write(CFG_DIEL, 64'h0000_0000_5000_0000);
        cfg_write(CFG_LJ_CUT, 64'h0000_0000_0280_0000);
        cfg_write(CFG_COUL_CUT, 64'h0000_0000_0C00_0000);
        idle_pct = 66;
        random_pairs(350);
        drain();

        cfg_write(CFG_DIEL, 64'hFFFF_FFFF);
        cfg_write(CFG_LJ_CUT, 64'h0000_0000_0A00_0000);
        cfg_write(CFG_TYPE1, rand_type_params());
        cfg_write(CFG_TYPE3, rand_type_params());
        idle_pct = 0;
        random_pairs(350);
        drain();

        cfg_write(CFG_DIEL, {32'd0, $urandom()});
        cfg_write(CFG_TYPE0, {$urandom(), $urandom()});
        cfg_write(CFG_TYPE2, rand_type_params());
        idle_pct = 23;
        random_pairs(350);

        start <= 0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (80) @(posedge i_clk);
        $display("Checked %0d pair energies over several register settings and idle rates",
                 checked);
        $display("Saturated results: %0d, coincident results: %0d", sat_seen, coinc_seen);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
